// File: hdl/typed_stack_bytecode_executor_defines.svh
// Assertion macros used by the executor back end (tsbe_execute).
`ifndef TYPED_STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define TYPED_STACK_BYTECODE_EXECUTOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TSBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define TSBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hdl/tsbe_pkg.sv
// Shared types, opcodes and status codes of the bytecode executor.
`default_nettype none
package tsbe_pkg;
   localparam int StackDepthDefault = 256;
   localparam logic [7:0] OP_CONST      = 8'd0;
   localparam logic [7:0] OP_TRUE       = 8'd1;
   localparam logic [7:0] OP_PUSH_FALSE = 8'd2;
   localparam logic [7:0] OP_NEG        = 8'd3;
   localparam logic [7:0] OP_ADD        = 8'd4;
   localparam logic [7:0] OP_SUB        = 8'd5;
   localparam logic [7:0] OP_MUL        = 8'd6;
   localparam logic [7:0] OP_DIV        = 8'd7;
   localparam logic [7:0] OP_EQ         = 8'd8;
   localparam logic [7:0] OP_LT         = 8'd9;
   localparam logic [7:0] OP_EMIT       = 8'd10;
   localparam logic [7:0] OP_POP        = 8'd11;
   localparam logic [7:0] OP_HALT       = 8'd12;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_PRINT = 3'd1;
   localparam logic [2:0] ST_HALT  = 3'd2;
   localparam logic [2:0] ST_TYPE  = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;
   localparam logic [2:0] ST_BADOP = 3'd5;
   localparam logic [2:0] ST_UNDER = 3'd6;
   localparam logic [2:0] ST_OVER  = 3'd7;

   typedef enum logic [3:0] {
      K_PUSH, K_NEG, K_ADD, K_SUB, K_MUL, K_DIV, K_EQ, K_LT, K_PRINT, K_POP,
      K_HALT, K_BAD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [32:0] push_val;
      logic [1:0]  need;
      logic [15:0] line;
   } cmd_type;
endpackage
`default_nettype wire

// File: hdl/tsbe_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module tsbe_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/tsbe_decode.sv
// Front end: accepts a request transfer and classifies it into a command.
`default_nettype none
module tsbe_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_type,
   input  wire logic signed [31:0] req_const_value,
   input  wire logic              req_const_is_bool,
   input  wire logic [15:0]       req_line_number,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output tsbe_pkg::cmd_type      cmd
);
   logic [1:0]              count_ff, count_in;
   tsbe_pkg::cmd_type       q_ff [2];
   logic                    wp_ff, wp_in, rp_ff, rp_in;
   tsbe_pkg::cmd_type       dec;
   logic                    push, pop;

   always_comb begin
      dec.line = req_line_number;
      dec.push_val = {1'b0, req_const_value};
      dec.need = 2'd0;
      unique case (req_type)
         tsbe_pkg::OP_CONST: begin
            dec.kind = tsbe_pkg::K_PUSH;
            if (req_const_is_bool) dec.push_val = {1'b1, 31'd0, req_const_value[0]};
         end
         tsbe_pkg::OP_TRUE: begin
            dec.kind = tsbe_pkg::K_PUSH; dec.push_val = {1'b1, 32'd1};
         end
         tsbe_pkg::OP_PUSH_FALSE: begin
            dec.kind = tsbe_pkg::K_PUSH; dec.push_val = {1'b1, 32'd0};
         end
         tsbe_pkg::OP_NEG:   begin dec.kind = tsbe_pkg::K_NEG;   dec.need = 2'd1; end
         tsbe_pkg::OP_ADD:   begin dec.kind = tsbe_pkg::K_ADD;   dec.need = 2'd2; end
         tsbe_pkg::OP_SUB:   begin dec.kind = tsbe_pkg::K_SUB;   dec.need = 2'd2; end
         tsbe_pkg::OP_MUL:   begin dec.kind = tsbe_pkg::K_MUL;   dec.need = 2'd2; end
         tsbe_pkg::OP_DIV:   begin dec.kind = tsbe_pkg::K_DIV;   dec.need = 2'd2; end
         tsbe_pkg::OP_EQ:    begin dec.kind = tsbe_pkg::K_EQ;    dec.need = 2'd2; end
         tsbe_pkg::OP_LT:    begin dec.kind = tsbe_pkg::K_LT;    dec.need = 2'd2; end
         tsbe_pkg::OP_EMIT:  begin dec.kind = tsbe_pkg::K_PRINT; dec.need = 2'd1; end
         tsbe_pkg::OP_POP:   begin dec.kind = tsbe_pkg::K_POP;   dec.need = 2'd1; end
         tsbe_pkg::OP_HALT:  dec.kind = tsbe_pkg::K_HALT;
         default:            dec.kind = tsbe_pkg::K_BAD;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = q_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop = cmd_valid && cmd_ready;
   assign wp_in = push ? ~wp_ff : wp_ff;
   assign rp_in = pop ? ~rp_ff : rp_ff;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         count_ff <= count_in; wp_ff <= wp_in; rp_ff <= rp_in;
      end
      if (push) q_ff[wp_ff] <= dec;
   end
endmodule
`default_nettype wire

// File: hdl/tsbe_divider.sv
// Iterative unsigned divider, one quotient bit per cycle.
`default_nettype none
module tsbe_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] q_ff, d_ff;
   logic [32:0] r_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [32:0] trial;
   logic [32:0] shifted;

   assign shifted = {r_ff[31:0], q_ff[31]};
   assign trial = shifted - {1'b0, d_ff};
   assign quotient = q_ff;
   assign done = busy_ff && (cnt_ff == 6'd32);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= 6'd0;
      end else if (start) begin
         busy_ff <= 1'b1; cnt_ff <= 6'd0;
         q_ff <= dividend; d_ff <= divisor; r_ff <= 33'd0;
      end else if (busy_ff && cnt_ff != 6'd32) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial[32]) begin
            r_ff <= trial; q_ff <= {q_ff[30:0], 1'b1};
         end else begin
            r_ff <= shifted; q_ff <= {q_ff[30:0], 1'b0};
         end
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// File: hdl/tsbe_execute.sv
// Back end: executes commands against the stack and produces responses.
`default_nettype none
`include "typed_stack_bytecode_executor_defines.svh"
module tsbe_execute #(
   parameter int StackDepth = tsbe_pkg::StackDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire tsbe_pkg::cmd_type  cmd,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_print_value,
   output logic                    rsp_print_is_bool,
   output logic [15:0]             rsp_error_line
);
   localparam int AW = $clog2(StackDepth);
   localparam int DW = $clog2(StackDepth + 1);

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_WAIT, S_DIV, S_RESP} state_type;

   state_type         state_ff;
   tsbe_pkg::cmd_type c_ff;
   logic [DW-1:0]     depth_ff;
   logic [32:0]       top_ff;
   logic [32:0]       a_ff;
   logic [2:0]        st_ff;
   logic [31:0]       pv_ff;
   logic              pb_ff;
   logic [15:0]       el_ff;
   logic              ram_we;
   logic [AW-1:0]     ram_wa, ram_ra;
   logic [32:0]       ram_wd, ram_rd;
   logic              div_start, div_done;
   logic [31:0]       div_q, abs_a, abs_b;
   logic [31:0]       prod_ff;
   logic              full;

   // Entries below the top live in the RAM; the top is held in top_ff.
   tsbe_ram #(.Width(33), .Depth(StackDepth)) u_ram (
      .clock, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign abs_a = a_ff[31] ? (32'd0 - a_ff[31:0]) : a_ff[31:0];
   assign abs_b = top_ff[31] ? (32'd0 - top_ff[31:0]) : top_ff[31:0];
   tsbe_divider u_div (
      .clock, .reset, .start(div_start), .dividend(abs_a), .divisor(abs_b),
      .done(div_done), .quotient(div_q)
   );

   assign full = (depth_ff == DW'(StackDepth));
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_print_value = pv_ff;
   assign rsp_print_is_bool = pb_ff;
   assign rsp_error_line = el_ff;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = AW'(depth_ff - DW'(1));
      ram_wd = top_ff;
      ram_ra = AW'(depth_ff - DW'(2));
      div_start = 1'b0;
      if (state_ff == S_IDLE && cmd_valid && cmd.kind == tsbe_pkg::K_PUSH &&
          depth_ff != '0 && !full)
         ram_we = 1'b1;
      if (state_ff == S_WAIT && c_ff.kind == tsbe_pkg::K_DIV && !a_ff[32] &&
          !top_ff[32] && top_ff[31:0] != 32'd0)
         div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_ff[31:0] * top_ff[31:0];
      if (reset) begin
         state_ff <= S_IDLE; depth_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               c_ff <= cmd;
               pv_ff <= 32'd0; pb_ff <= 1'b0; el_ff <= 16'd0; st_ff <= tsbe_pkg::ST_OK;
               state_ff <= S_RESP;
               priority if (cmd.kind == tsbe_pkg::K_BAD) begin
                  st_ff <= tsbe_pkg::ST_BADOP; el_ff <= cmd.line; depth_ff <= '0;
               end else if (depth_ff < DW'(cmd.need)) begin
                  st_ff <= tsbe_pkg::ST_UNDER; el_ff <= cmd.line; depth_ff <= '0;
               end else if (cmd.kind == tsbe_pkg::K_PUSH) begin
                  if (full) begin
                     st_ff <= tsbe_pkg::ST_OVER; el_ff <= cmd.line; depth_ff <= '0;
                  end else begin
                     top_ff <= cmd.push_val; depth_ff <= depth_ff + DW'(1);
                  end
               end else if (cmd.kind == tsbe_pkg::K_HALT) begin
                  st_ff <= tsbe_pkg::ST_HALT; depth_ff <= '0;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               // The entry under the top is now on the RAM read port.
               if (c_ff.need == 2'd2) a_ff <= ram_rd;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_RESP;
               unique case (c_ff.kind)
                  tsbe_pkg::K_PRINT, tsbe_pkg::K_POP: begin
                     if (c_ff.kind == tsbe_pkg::K_PRINT) begin
                        st_ff <= tsbe_pkg::ST_PRINT; pv_ff <= top_ff[31:0];
                        pb_ff <= top_ff[32];
                     end
                     top_ff <= ram_rd; depth_ff <= depth_ff - DW'(1);
                  end
                  tsbe_pkg::K_NEG: begin
                     if (top_ff[32]) begin
                        st_ff <= tsbe_pkg::ST_TYPE; el_ff <= c_ff.line; depth_ff <= '0;
                     end else top_ff <= {1'b0, 32'd0 - top_ff[31:0]};
                  end
                  default: begin
                     if (c_ff.kind == tsbe_pkg::K_EQ ? (a_ff[32] != top_ff[32])
                                                      : (a_ff[32] || top_ff[32])) begin
                        st_ff <= tsbe_pkg::ST_TYPE; el_ff <= c_ff.line; depth_ff <= '0;
                     end else if (c_ff.kind == tsbe_pkg::K_DIV && top_ff[31:0] == 32'd0) begin
                        st_ff <= tsbe_pkg::ST_DIV0; el_ff <= c_ff.line; depth_ff <= '0;
                     end else begin
                        depth_ff <= depth_ff - DW'(1);
                        unique case (c_ff.kind)
                           tsbe_pkg::K_ADD: top_ff <= {1'b0, a_ff[31:0] + top_ff[31:0]};
                           tsbe_pkg::K_SUB: top_ff <= {1'b0, a_ff[31:0] - top_ff[31:0]};
                           tsbe_pkg::K_MUL: top_ff <= {1'b0, prod_ff};
                           tsbe_pkg::K_EQ:
                              top_ff <= {1'b1, 31'd0, a_ff[31:0] == top_ff[31:0]};
                           tsbe_pkg::K_LT:
                              top_ff <= {1'b1, 31'd0, $signed(a_ff[31:0]) <
                                                     $signed(top_ff[31:0])};
                           default: begin
                              state_ff <= S_DIV;
                              if (div_done) begin
                                 state_ff <= S_RESP;
                                 top_ff <= {1'b0, (a_ff[31] != top_ff[31]) ?
                                            32'd0 - div_q : div_q};
                              end else depth_ff <= depth_ff;
                           end
                        endcase
                     end
                  end
               endcase
            end
            S_RESP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TSBE_ASSERT_IMP(a_depth_range, clock, reset, 1'b1, depth_ff <= DW'(StackDepth),
      "stack depth exceeds capacity")
   `TSBE_ASSERT_IMP(a_err_line, clock, reset, rsp_valid && rsp_status < tsbe_pkg::ST_TYPE,
      rsp_error_line == 16'd0, "error line set without an error")
   `TSBE_ASSERT_IMP(a_err_clear, clock, reset, rsp_valid && rsp_status >= tsbe_pkg::ST_HALT,
      depth_ff == '0, "stack not cleared after halt or error")
endmodule
`default_nettype wire

// File: hdl/typed_stack_bytecode_executor.sv
// Top level of the typed stack bytecode executor.
// Each request transfer carries one instruction and yields exactly one response
// transfer. A two-entry command queue separates decode from execution. Pushes,
// halt and acceptance errors respond from idle; pops and arithmetic pass fetch,
// wait and S_DIV for the registered read of the entry under the top; divide
// waits on the bit-serial divider. The stack top is held in a register.
`default_nettype none
module typed_stack_bytecode_executor #(
   parameter int StackDepth = tsbe_pkg::StackDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_type,
   input  wire logic signed [31:0] req_const_value,
   input  wire logic               req_const_is_bool,
   input  wire logic [15:0]        req_line_number,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_print_value,
   output logic                    rsp_print_is_bool,
   output logic [15:0]             rsp_error_line
);
   logic              cmd_valid, cmd_ready;
   tsbe_pkg::cmd_type cmd;

   tsbe_decode u_dec (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_const_value,
      .req_const_is_bool, .req_line_number, .cmd_valid, .cmd_ready, .cmd
   );

   tsbe_execute #(.StackDepth(StackDepth)) u_exe (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_print_value, .rsp_print_is_bool, .rsp_error_line
   );
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the typed stack bytecode executor.
`default_nettype none
module testbench;
   import tsbe_pkg::*;

   localparam int Depth = StackDepthDefault;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] value;
      logic        is_bool;
      logic [15:0] line;
   } outcome_type;

   typedef struct {
      logic [7:0]  op;
      logic [31:0] cval;
      logic        cbool;
      logic [15:0] line;
      logic        typed;
      logic [2:0]  status;
   } instr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_type = '0;
   logic signed [31:0] req_const_value = '0;
   logic req_const_is_bool = 1'b0;
   logic [15:0] req_line_number = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_print_value;
   logic rsp_print_is_bool;
   logic [15:0] rsp_error_line;

   logic [32:0] vm_stack [Depth];
   int unsigned vm_depth = 0;
   outcome_type awaited [$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int op_seen [14];

   typed_stack_bytecode_executor DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, q;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic outcome_type execute(instr_type it);
      outcome_type o;
      int unsigned need;
      logic [32:0] a, b, r;
      logic push;
      o = '{ST_OK, 32'd0, 1'b0, 16'd0};
      a = '0;
      b = '0;
      r = '0;
      push = 1'b1;
      need = 0;
      if (it.op >= OP_ADD && it.op <= OP_LT) need = 2;
      else if (it.op == OP_NEG || it.op == OP_EMIT || it.op == OP_POP) need = 1;
      if (it.op > OP_HALT) begin
         o.status = ST_BADOP;
      end else if (vm_depth < need) begin
         o.status = ST_UNDER;
      end else if (it.op <= OP_PUSH_FALSE) begin
         if (it.op == OP_CONST) r = it.cbool ? {1'b1, 31'd0, it.cval[0]} : {1'b0, it.cval};
         else r = {1'b1, 31'd0, it.op == OP_TRUE};
         if (vm_depth >= Depth) o.status = ST_OVER;
         else vm_stack[vm_depth++] = r;
      end else if (it.op == OP_HALT) begin
         o.status = ST_HALT;
      end else begin
         if (need == 2) begin
            b = vm_stack[vm_depth - 1];
            a = vm_stack[vm_depth - 2];
         end else begin
            a = vm_stack[vm_depth - 1];
         end
         vm_depth -= need;
         if (it.op == OP_EMIT || it.op == OP_POP) begin
            push = 1'b0;
            if (it.op == OP_EMIT) begin
               o.status = ST_PRINT;
               o.value = a[31:0];
               o.is_bool = a[32];
            end
         end else if (it.op == OP_EQ) begin
            if (a[32] != b[32]) o.status = ST_TYPE;
            else r = {1'b1, 31'd0, a[31:0] == b[31:0]};
         end else if (a[32] || (need == 2 && b[32])) begin
            o.status = ST_TYPE;
         end else begin
            case (it.op)
               OP_NEG: r = {1'b0, -a[31:0]};
               OP_ADD: r = {1'b0, a[31:0] + b[31:0]};
               OP_SUB: r = {1'b0, a[31:0] - b[31:0]};
               OP_MUL: r = {1'b0, a[31:0] * b[31:0]};
               OP_DIV: begin
                  if (b[31:0] == 0) o.status = ST_DIV0;
                  else r = {1'b0, quotient(a[31:0], b[31:0])};
               end
               default: r = {1'b1, 31'd0, $signed(a[31:0]) < $signed(b[31:0])};
            endcase
         end
         if (push && o.status == ST_OK) vm_stack[vm_depth++] = r;
      end
      if (o.status >= ST_HALT) vm_depth = 0;
      if (o.status >= ST_TYPE) o.line = it.line;
      return o;
   endfunction

   task automatic send(instr_type it);
      outcome_type o;
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.op;
      req_const_value <= it.cval;
      req_const_is_bool <= it.cbool;
      req_line_number <= it.line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      o = execute(it);
      if (it.typed && o.status != it.status) begin
         $display("%0t: table status expected %0d actual prediction %0d",
            $time, it.status, o.status);
         errors++;
      end
      awaited.insert(awaited.size(), o);
      op_seen[it.op > 13 ? 13 : it.op]++;
      sent++;
   endtask

   function automatic instr_type mk(logic [7:0] op, logic [31:0] cval = 0,
         logic cbool = 0, logic [15:0] line = 0);
      instr_type it;
      it = '{op, cval, cbool, line, 1'b0, ST_OK};
      return it;
   endfunction

   function automatic instr_type mkt(logic [7:0] op, logic [2:0] st,
         logic [31:0] cval = 0, logic cbool = 0, logic [15:0] line = 0);
      instr_type it;
      it = '{op, cval, cbool, line, 1'b1, st};
      return it;
   endfunction

   function automatic instr_type random_instr(bit wellformed);
      instr_type it;
      logic [31:0] v;
      logic [7:0] op;
      v = $urandom;
      case ($urandom_range(5))
         0: v = 32'h8000_0000;
         1: v = 32'hFFFF_FFFF;
         2: v = $urandom_range(3);
         default: ;
      endcase
      if (!wellformed) begin
         op = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 13)) : 8'($urandom_range(12));
      end else if (vm_depth < 2 || (vm_depth < 40 && $urandom_range(2) == 0)) begin
         op = ($urandom_range(3) == 0) ? 8'($urandom_range(2)) : OP_CONST;
      end else begin
         op = 8'($urandom_range(OP_POP, OP_NEG));
         if ($urandom_range(50) == 0) op = OP_HALT;
      end
      it = mk(op, v, wellformed ? ($urandom_range(5) == 0) : 1'($urandom),
         16'($urandom));
      return it;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected transfer status %0d", $time, rsp_status);
               errors++;
            end else begin
               outcome_type e;
               e = awaited.pop_front();
               received++;
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
                  errors++;
               end
               if (rsp_print_value !== e.value) begin
                  $display("%0t: print_value expected %0d actual %0d",
                     $time, $signed(e.value), rsp_print_value);
                  errors++;
               end
               if (rsp_print_is_bool !== e.is_bool) begin
                  $display("%0t: print_is_bool expected %0b actual %0b",
                     $time, e.is_bool, rsp_print_is_bool);
                  errors++;
               end
               if (rsp_error_line !== e.line) begin
                  $display("%0t: error_line expected %0d actual %0d",
                     $time, e.line, rsp_error_line);
                  errors++;
               end
            end
         end
         rsp_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      instr_type directed [$];
      int n;
      directed = '{
         mkt(OP_POP, ST_UNDER, 0, 0, 16'hFFFF),
         mkt(OP_ADD, ST_UNDER, 0, 0, 16'd1),
         mkt(8'd13, ST_BADOP, 0, 0, 16'd2),
         mkt(8'd255, ST_BADOP, 0, 0, 16'hFFFF),
         mkt(OP_CONST, ST_OK, 32'h8000_0000),
         mkt(OP_CONST, ST_OK, 32'hFFFF_FFFF),
         mk(OP_DIV),
         mkt(OP_EMIT, ST_PRINT),
         mkt(OP_CONST, ST_OK, 32'h7FFF_FFFF),
         mkt(OP_CONST, ST_OK, 32'h0),
         mkt(OP_DIV, ST_DIV0, 0, 0, 16'd7),
         mkt(OP_TRUE, ST_OK),
         mkt(OP_NEG, ST_TYPE, 0, 0, 16'd9),
         mkt(OP_CONST, ST_OK, 32'hFFFF_FFFE, 1'b1),
         mkt(OP_PUSH_FALSE, ST_OK),
         mk(OP_EQ),
         mkt(OP_CONST, ST_OK, 32'd5),
         mk(OP_LT, 0, 0, 16'd11),
         mkt(OP_CONST, ST_OK, 32'd3),
         mkt(OP_CONST, ST_OK, 32'hFFFF_FFF9),
         mk(OP_MUL), mk(OP_SUB), mk(OP_CONST, 32'd1), mk(OP_ADD),
         mkt(OP_HALT, ST_HALT)
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle = 19;
      recv_idle = 46;
      foreach (directed[i]) send(directed[i]);
      // Fill the stack to the brim and beyond.
      for (int i = 0; i <= Depth; i++) send(mk(OP_CONST, $urandom, 1'($urandom), 16'($urandom)));
      send(mk(OP_EMIT));
      send(mk(OP_HALT));
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 19 : (p == 1) ? 46 : 0;
         recv_idle = (p == 0) ? 46 : (p == 1) ? 19 : 0;
         n = 0;
         while (n < 300) begin
            send(random_instr($urandom_range(9) != 0));
            n++;
         end
         req_valid <= 1'b0;
         while (awaited.size() != 0) @(posedge clock);
      end
      repeat (60) @(posedge clock);
      $display("Ran %0d transfers out, %0d back; const %0d div %0d print %0d bad %0d.",
         sent, received, op_seen[OP_CONST], op_seen[OP_DIV], op_seen[OP_EMIT], op_seen[13]);
      if (errors == 0 && awaited.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
